// File: rtl/core/ptmt_pkg.sv
// ptmt_pkg: shared types, request codes and tag compare functions for the
// pending tag minimum tracker. no dependencies.
`timescale 1ns / 1ps

package ptmt_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int TIME_W       = 64;
  localparam int MICRO_W      = 32;

  localparam logic [TIME_W-1:0]  FOREVER_TIME  = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic [MICRO_W-1:0] FOREVER_MICRO = {MICRO_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_PURGE = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_PURGE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                      valid;
    logic signed [TIME_W-1:0]  tm;
    logic [MICRO_W-1:0]        ms;
  } entry_t;

  // strict order: a before b
  function automatic logic tag_lt(input logic signed [TIME_W-1:0] a_tm,
                                  input logic [MICRO_W-1:0] a_ms,
                                  input logic signed [TIME_W-1:0] b_tm,
                                  input logic [MICRO_W-1:0] b_ms);
    logic res;
    if (a_tm != b_tm) begin
      res = ($signed(a_tm) < $signed(b_tm));
    end else begin
      res = (a_ms < b_ms);
    end
    return res;
  endfunction

  function automatic logic tag_le(input logic signed [TIME_W-1:0] a_tm,
                                  input logic [MICRO_W-1:0] a_ms,
                                  input logic signed [TIME_W-1:0] b_tm,
                                  input logic [MICRO_W-1:0] b_ms);
    return !tag_lt(b_tm, b_ms, a_tm, a_ms);
  endfunction

endpackage

// File: rtl/core/ptmt_cell.sv
// ptmt_cell: one slot of the sorted tag chain.
// depends on ptmt_pkg for the entry type, cell ops and tag compare.
`timescale 1ns / 1ps

module ptmt_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ptmt_pkg::cell_op_t                op,
  input  logic signed [ptmt_pkg::TIME_W-1:0] new_tm,
  input  logic [ptmt_pkg::MICRO_W-1:0]      new_ms,
  input  ptmt_pkg::entry_t                  left_ent,
  input  logic                              left_gt,
  input  ptmt_pkg::entry_t                  right_ent,
  output ptmt_pkg::entry_t                  ent,
  output logic                              gt
);

  logic                               valid_r, valid_nxt;
  logic signed [ptmt_pkg::TIME_W-1:0] tm_r, tm_nxt;
  logic [ptmt_pkg::MICRO_W-1:0]       ms_r, ms_nxt;

  // new tag goes at or before this slot
  assign gt = !valid_r || ptmt_pkg::tag_lt(new_tm, new_ms, tm_r, ms_r);

  assign ent.valid = valid_r;
  assign ent.tm    = tm_r;
  assign ent.ms    = ms_r;

  always_comb begin
    valid_nxt = valid_r;
    tm_nxt    = tm_r;
    ms_nxt    = ms_r;
    case (op)
      ptmt_pkg::CELL_INSERT: begin
        if (gt && left_gt) begin
          valid_nxt = left_ent.valid;
          tm_nxt    = left_ent.tm;
          ms_nxt    = left_ent.ms;
        end else if (gt) begin
          valid_nxt = 1'b1;
          tm_nxt    = new_tm;
          ms_nxt    = new_ms;
        end
      end
      ptmt_pkg::CELL_SHIFT: begin
        valid_nxt = right_ent.valid;
        tm_nxt    = right_ent.tm;
        ms_nxt    = right_ent.ms;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tm_r <= tm_nxt;
    ms_r <= ms_nxt;
  end

endmodule

// File: rtl/core/pending_tag_min_tracker.sv
// pending_tag_min_tracker: top level, request sequencer around a sorted chain of cells.
// depends on ptmt_pkg and ptmt_cell.
`timescale 1ns / 1ps

// usage
//   a request is taken at a rising edge with start high and busy low; it carries
//   in_req_type (add, purge up to a tag, query; code 3 acts as a query) and a tag
//   made of in_tag_time (signed) and in_tag_microstep
//   each request gives one result, shown for exactly one cycle with out_valid high:
//   out_status (add dropped, store full), out_store_empty and the least stored tag
//   on out_min_time / out_min_microstep (the forever tag when empty)
//   the receiver cannot stall; the result is gone after its strobe cycle
// request sequencing
//   the cells stay sorted, least tag in cell 0, so the minimum is always at hand
//   query: strobe in the cycle after acceptance, a new request every cycle
//   add: the chain inserts in ST_ADD unless full, with the strobe in the cycle after
//   purge: the chain shifts down by one cell per cycle while cell 0 is at or
//     below the purge tag, then the strobe follows in the ST_DONE state
//   busy is low during the strobe cycle, so the next request may start there
// reset
//   synchronous active-low reset empties the chain (valid bits only) and idles
//   the sequencer; no clearing pass is needed

module pending_tag_min_tracker #(
  parameter int CAPACITY = ptmt_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_req_type,
  input  logic signed [ptmt_pkg::TIME_W-1:0] in_tag_time,
  input  logic [ptmt_pkg::MICRO_W-1:0]       in_tag_microstep,
  output logic                               out_valid,
  output logic                               out_status,
  output logic                               out_store_empty,
  output logic signed [ptmt_pkg::TIME_W-1:0] out_min_time,
  output logic [ptmt_pkg::MICRO_W-1:0]       out_min_microstep
);

  ptmt_pkg::state_t state_r, state_nxt;

  // latched request
  logic signed [ptmt_pkg::TIME_W-1:0] tag_tm_r;
  logic [ptmt_pkg::MICRO_W-1:0]       tag_ms_r;
  logic                               full_r, full_nxt;

  logic                 accept;
  ptmt_pkg::cell_op_t   cell_op;
  ptmt_pkg::entry_t     ent [CAPACITY];
  logic                 gt  [CAPACITY];
  ptmt_pkg::entry_t     empty_ent;

  assign empty_ent = '{valid: 1'b0, tm: '0, ms: '0};

  // cell chain: cell 0 holds the least tag, valid cells form a prefix
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ptmt_pkg::entry_t left_ent;
    ptmt_pkg::entry_t right_ent;
    logic             left_gt;

    if (i == 0) begin : g_first
      assign left_ent = empty_ent;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[i-1];
      assign left_gt  = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = empty_ent;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    ptmt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (cell_op),
      .new_tm    (tag_tm_r),
      .new_ms    (tag_ms_r),
      .left_ent  (left_ent),
      .left_gt   (left_gt),
      .right_ent (right_ent),
      .ent       (ent[i]),
      .gt        (gt[i])
    );
  end

  assign busy   = (state_r == ptmt_pkg::ST_ADD) || (state_r == ptmt_pkg::ST_PURGE);
  assign accept = start && !busy;

  // sequencer: next state and cell command
  always_comb begin
    state_nxt = state_r;
    full_nxt  = full_r;
    cell_op   = ptmt_pkg::CELL_HOLD;
    case (state_r)
      ptmt_pkg::ST_IDLE, ptmt_pkg::ST_DONE: begin
        state_nxt = ptmt_pkg::ST_IDLE;
        if (accept) begin
          full_nxt = 1'b0;
          case (in_req_type)
            ptmt_pkg::REQ_ADD:   state_nxt = ptmt_pkg::ST_ADD;
            ptmt_pkg::REQ_PURGE: state_nxt = ptmt_pkg::ST_PURGE;
            default:             state_nxt = ptmt_pkg::ST_DONE;
          endcase
        end
      end
      ptmt_pkg::ST_ADD: begin
        // a full chain has its last cell occupied
        if (ent[CAPACITY-1].valid) begin
          full_nxt = 1'b1;
        end else begin
          cell_op = ptmt_pkg::CELL_INSERT;
        end
        state_nxt = ptmt_pkg::ST_DONE;
      end
      ptmt_pkg::ST_PURGE: begin
        // drop the head while it is at or below the purge tag
        if (ent[0].valid && ptmt_pkg::tag_le(ent[0].tm, ent[0].ms, tag_tm_r, tag_ms_r)) begin
          cell_op = ptmt_pkg::CELL_SHIFT;
        end else begin
          state_nxt = ptmt_pkg::ST_DONE;
        end
      end
      default: begin
        state_nxt = ptmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptmt_pkg::ST_IDLE;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      full_r  <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_tm_r <= in_tag_time;
      tag_ms_r <= in_tag_microstep;
    end
  end

  // result: empty flag and minimum straight from the head cell
  assign out_valid         = (state_r == ptmt_pkg::ST_DONE);
  assign out_status        = full_r;
  assign out_store_empty   = !ent[0].valid;
  assign out_min_time      = ent[0].valid ? ent[0].tm : ptmt_pkg::FOREVER_TIME;
  assign out_min_microstep = ent[0].valid ? ent[0].ms : ptmt_pkg::FOREVER_MICRO;

  // head and its neighbor stay in order, cell 1 is occupied only with cell 0 occupied
  generate
    if (CAPACITY > 1) begin : g_chk
      a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        ent[1].valid |-> (ent[0].valid &&
                          !ptmt_pkg::tag_lt(ent[1].tm, ent[1].ms, ent[0].tm, ent[0].ms)))
        else $error("cell chain head out of order");
    end
  endgenerate

  // a dropped add only happens with the store full, so it can never report empty
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> !out_store_empty)
    else $error("dropped add reported with empty store");

  // an add state is always followed by the done state
  a_add_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptmt_pkg::ST_ADD) |=> (state_r == ptmt_pkg::ST_DONE))
    else $error("add did not complete in one cycle");

  // status is only ever raised by an add
  a_status_from_add: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> ($past(state_r) == ptmt_pkg::ST_ADD))
    else $error("status raised outside an add");

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for pending_tag_min_tracker, a directed table followed by
// phased random traffic, checked against a bounded tag multiset kept in the bench.
// depends on ptmt_pkg and the pending_tag_min_tracker rtl.
`timescale 1ns / 1ps

module tb_top;
  import ptmt_pkg::*;

  localparam int SLOTS       = CAPACITY_DEF;
  localparam int PHASE_ITEMS = 645;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 80;

  // request code 3 is not in the enum, the block treats it as a query
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // traffic mixes for the random episodes
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic signed [TIME_W-1:0] TIME_NEG1 = {TIME_W{1'b1}};

  typedef struct packed {
    logic                      status;
    logic                      store_empty;
    logic signed [TIME_W-1:0]  min_time;
    logic [MICRO_W-1:0]        min_micro;
  } min_report_t;

  typedef struct packed {
    logic [1:0]                rq;
    logic signed [TIME_W-1:0]  tm;
    logic [MICRO_W-1:0]        ms;
    logic                      typed;
    min_report_t               want;
  } stim_row_t;

  // hand-written results for rows whose outcome is obvious
  localparam min_report_t EMPTY_REPORT   = '{1'b0, 1'b1, FOREVER_TIME, FOREVER_MICRO};
  localparam min_report_t LOWEST_REPORT  = '{1'b0, 1'b0, TIME_MIN, {MICRO_W{1'b0}}};
  localparam min_report_t FOREVER_STORED = '{1'b0, 1'b0, FOREVER_TIME, FOREVER_MICRO};
  localparam min_report_t NO_REPORT      = '0;

  // directed table: empty store, extremes of both tag fields, duplicates, purges
  // with and without matches, the spare request code and a stored forever tag
  localparam int DIRECTED_N = 17;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{REQ_QUERY, 64'sd0,        32'd0,         1'b1, EMPTY_REPORT},   // query on empty
    '{REQ_PURGE, 64'sd0,        32'd0,         1'b1, EMPTY_REPORT},   // purge on empty
    '{REQ_SPARE, TIME_NEG1,     FOREVER_MICRO, 1'b1, EMPTY_REPORT},   // spare code on empty
    '{REQ_ADD,   TIME_MIN,      32'd0,         1'b1, LOWEST_REPORT},  // lowest possible tag
    '{REQ_ADD,   FOREVER_TIME,  FOREVER_MICRO, 1'b1, LOWEST_REPORT},  // forever tag stored
    '{REQ_ADD,   64'sd0,        32'd5,         1'b0, NO_REPORT},
    '{REQ_ADD,   64'sd0,        32'd3,         1'b0, NO_REPORT},
    '{REQ_ADD,   64'sd0,        32'd3,         1'b0, NO_REPORT},      // duplicate kept
    '{REQ_ADD,   TIME_NEG1,     FOREVER_MICRO, 1'b0, NO_REPORT},
    '{REQ_PURGE, TIME_MIN,      32'd0,         1'b0, NO_REPORT},      // exact match only
    '{REQ_PURGE, TIME_NEG1,     32'hFFFFFFFE,  1'b0, NO_REPORT},      // no match, one below
    '{REQ_PURGE, 64'sd0,        32'd3,         1'b0, NO_REPORT},      // both duplicates go
    '{REQ_QUERY, TIME_MIN,      FOREVER_MICRO, 1'b0, NO_REPORT},
    '{REQ_SPARE, FOREVER_TIME,  32'd0,         1'b0, NO_REPORT},
    '{REQ_PURGE, FOREVER_TIME,  32'hFFFFFFFE,  1'b1, FOREVER_STORED}, // only forever tag left
    '{REQ_ADD,   64'sd5,        32'd1,         1'b0, NO_REPORT},
    '{REQ_PURGE, FOREVER_TIME,  FOREVER_MICRO, 1'b1, EMPTY_REPORT}    // clears everything
  };

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_req_type;
  logic signed [TIME_W-1:0]  in_tag_time;
  logic [MICRO_W-1:0]        in_tag_microstep;
  logic                      out_valid;
  logic                      out_status;
  logic                      out_store_empty;
  logic signed [TIME_W-1:0]  out_min_time;
  logic [MICRO_W-1:0]        out_min_microstep;

  // bench copy of the tag store
  logic signed [TIME_W-1:0]  held_time  [SLOTS];
  logic [MICRO_W-1:0]        held_micro [SLOTS];
  logic                      held_valid [SLOTS];
  int                        held_count = 0;

  min_report_t expected_mins [$];

  int idle_pct      = 0;
  int error_count   = 0;
  int checked_count = 0;
  int add_count     = 0;
  int drop_count    = 0;
  int purge_count   = 0;
  int query_count   = 0;
  int peak_fill     = 0;
  int cycle_count   = 0;

  pending_tag_min_tracker #(
    .CAPACITY(SLOTS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_tag_time      (in_tag_time),
    .in_tag_microstep (in_tag_microstep),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_store_empty  (out_store_empty),
    .out_min_time     (out_min_time),
    .out_min_microstep(out_min_microstep)
  );

  always #1 clk = ~clk;

  // watchdog, reckoned from every request being a full-store purge under heavy idling
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_mins.size());
      $display("Verification failed");
      $finish;
    end
  end

  // flipping the sign bit turns signed time order into plain unsigned order,
  // and the microstep breaks ties as the low part of the key
  function automatic logic [TIME_W+MICRO_W-1:0] order_key(
    input logic signed [TIME_W-1:0] tm,
    input logic [MICRO_W-1:0]       ms);
    return {~tm[TIME_W-1], tm[TIME_W-2:0], ms};
  endfunction

  // least held tag, also refreshes the occupancy count
  function automatic min_report_t held_minimum();
    min_report_t rep;
    rep = EMPTY_REPORT;
    held_count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (held_valid[i]) begin
        if (held_count == 0 ||
            order_key(held_time[i], held_micro[i]) < order_key(rep.min_time, rep.min_micro)) begin
          rep.min_time  = held_time[i];
          rep.min_micro = held_micro[i];
        end
        held_count++;
      end
    end
    rep.store_empty = (held_count == 0);
    return rep;
  endfunction

  // apply one request to the bench store and give the report it should produce
  function automatic min_report_t track_request(
    input logic [1:0]               rq,
    input logic signed [TIME_W-1:0] tm,
    input logic [MICRO_W-1:0]       ms);
    min_report_t rep;
    int          free_idx;
    logic        dropped;
    free_idx = -1;
    dropped  = 1'b0;
    if (rq == REQ_ADD) begin
      // lowest free slot wins
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!held_valid[i]) free_idx = i;
      end
      if (free_idx < 0) begin
        dropped = 1'b1;
      end else begin
        held_time[free_idx]  = tm;
        held_micro[free_idx] = ms;
        held_valid[free_idx] = 1'b1;
      end
    end else if (rq == REQ_PURGE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (held_valid[i] && order_key(held_time[i], held_micro[i]) <= order_key(tm, ms)) begin
          held_valid[i] = 1'b0;
        end
      end
    end
    // query and the spare code leave the store alone
    rep = held_minimum();
    rep.status = dropped;
    return rep;
  endfunction

  // a random held tag, only called when the store is not empty
  function automatic void pick_held(output logic signed [TIME_W-1:0] tm,
                                    output logic [MICRO_W-1:0] ms);
    int sel;
    sel = $urandom_range(held_count - 1);
    tm  = '0;
    ms  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (held_valid[i]) begin
        if (sel == 0) begin
          tm = held_time[i];
          ms = held_micro[i];
        end
        sel--;
      end
    end
  endfunction

  // mostly a narrow window around zero so times collide and microsteps decide,
  // with the extremes and full-width values mixed in
  function automatic logic signed [TIME_W-1:0] pick_time();
    logic [TIME_W-1:0] v;
    case ($urandom_range(9))
      0: v = {$urandom, $urandom};
      1: v = TIME_MIN + $urandom_range(3);
      2: v = FOREVER_TIME - $urandom_range(3);
      default: v = 64'($urandom_range(16)) - 64'd8;
    endcase
    return v;
  endfunction

  function automatic logic [MICRO_W-1:0] pick_micro();
    logic [MICRO_W-1:0] v;
    case ($urandom_range(9))
      0: v = $urandom;
      1: v = FOREVER_MICRO - $urandom_range(2);
      default: v = $urandom_range(3);
    endcase
    return v;
  endfunction

  // present one request, hold it until the block takes it, then record what should come back
  task automatic issue_request(input logic [1:0]               rq,
                               input logic signed [TIME_W-1:0] tm,
                               input logic [MICRO_W-1:0]       ms,
                               input logic                     typed,
                               input min_report_t              typed_rep);
    min_report_t rep;
    // sender gaps, geometric so that some run several cycles
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start            <= 1'b1;
    in_req_type      <= rq;
    in_tag_time      <= tm;
    in_tag_microstep <= ms;
    // busy read here is the value from before the edge
    @(posedge clk);
    while (busy) @(posedge clk);
    rep = track_request(rq, tm, ms);
    expected_mins.push_back(typed ? typed_rep : rep);
    if (held_count > peak_fill) peak_fill = held_count;
    if (rq == REQ_ADD) begin
      add_count++;
      if (rep.status) drop_count++;
    end else if (rq == REQ_PURGE) begin
      purge_count++;
    end else begin
      query_count++;
    end
    // start stays high here, the next call or the drain decides
  endtask

  // stop sending until every outstanding result has been seen
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_mins.size() != 0);
  endtask

  // result checker, results cannot be stalled so every strobe is consumed
  always @(posedge clk) begin : check_results
    min_report_t want;
    if (rst_n && out_valid) begin
      if (expected_mins.size() == 0) begin
        $display("%0t: result with none outstanding, empty %0b min %0d/%0d", $time,
                 out_store_empty, out_min_time, out_min_microstep);
        error_count++;
      end else begin
        want = expected_mins.pop_front();
        checked_count++;
        if (out_status !== want.status) begin
          $display("%0t: status expected %0b, got %0b", $time, want.status, out_status);
          error_count++;
        end
        if (out_store_empty !== want.store_empty) begin
          $display("%0t: store_empty expected %0b, got %0b", $time, want.store_empty,
                   out_store_empty);
          error_count++;
        end
        if (out_min_time !== want.min_time) begin
          $display("%0t: min_time expected %0d, got %0d", $time, want.min_time, out_min_time);
          error_count++;
        end
        if (out_min_microstep !== want.min_micro) begin
          $display("%0t: min_microstep expected %0d, got %0d", $time, want.min_micro,
                   out_min_microstep);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [1:0]               rq;
    logic signed [TIME_W-1:0] tm;
    logic [MICRO_W-1:0]       ms;
    min_report_t              snap;
    int                       mode;
    int                       ep_len;
    int                       done;
    int                       r;
    int                       s;
    int                       add_cut;
    int                       purge_cut;

    rst_n            = 1'b0;
    start            = 1'b0;
    in_req_type      = REQ_QUERY;
    in_tag_time      = '0;
    in_tag_microstep = '0;
    for (int i = 0; i < SLOTS; i++) begin
      held_time[i]  = '0;
      held_micro[i] = '0;
      held_valid[i] = 1'b0;
    end

    // single synchronous reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows with light sender idling
    idle_pct = 7;
    foreach (DIRECTED_ROWS[i]) begin
      issue_request(DIRECTED_ROWS[i].rq, DIRECTED_ROWS[i].tm, DIRECTED_ROWS[i].ms,
                    DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    wait_drained();

    // three idling regimes: light, heavy, none
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 7 : (ph == 1) ? 47 : 0;
      done = 0;
      // each phase opens with a fill episode to drive the store toward full
      mode = MODE_FILL;
      while (done < PHASE_ITEMS) begin
        ep_len = $urandom_range(60, 140);
        add_cut   = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 30 : 50;
        purge_cut = (mode == MODE_FILL) ? 90 : 75;
        for (int k = 0; k < ep_len && done < PHASE_ITEMS; k++) begin
          r  = $urandom_range(99);
          tm = pick_time();
          ms = pick_micro();
          if (r < add_cut) begin
            rq = REQ_ADD;
          end else if (r < purge_cut) begin
            rq = REQ_PURGE;
            if (mode == MODE_FILL) begin
              // trim just the least tag so the store keeps growing
              snap = held_minimum();
              tm   = snap.min_time;
              ms   = snap.min_micro;
            end else begin
              s = $urandom_range(9);
              if (s >= 4 && s <= 6 && held_count > 0) begin
                // a held tag, one microstep either side or exact
                pick_held(tm, ms);
                ms = ms + $urandom_range(2) - 1;
              end else if (s == 7) begin
                snap = held_minimum();
                tm   = snap.min_time;
                ms   = snap.min_micro;
              end else if (s == 8) begin
                tm = TIME_MIN;
              end else if (s == 9) begin
                tm = FOREVER_TIME;
                ms = FOREVER_MICRO;
              end
            end
          end else begin
            rq = ($urandom_range(4) == 0) ? REQ_SPARE : REQ_QUERY;
          end
          issue_request(rq, tm, ms, 1'b0, NO_REPORT);
          done++;
        end
        mode = $urandom_range(MODE_MIXED);
      end
      // hold off the sender until the block has answered everything
      wait_drained();
    end

    // quiet tail in case the block sends anything extra
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d requests: %0d adds (%0d refused on a full store), %0d purges, %0d queries",
             add_count + purge_count + query_count, add_count, drop_count, purge_count,
             query_count);
    $display("checked %0d results, peak occupancy %0d of %0d slots, %0d mismatches",
             checked_count, peak_fill, SLOTS, error_count);
    if (error_count == 0 && expected_mins.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
